[rtl/ifs_pkg.sv]
// Shared types, constants and character helpers for the integer field scanner.
package ifs_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [1:0] CFG_BASE_MODE       = 2'd0;
  localparam logic [1:0] CFG_FIELD_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_GROUPING_ENABLE = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [6:0] NO_DIGIT = 7'd99;

  typedef enum logic [2:0] {
    B_AUTO = 3'd0,
    B_BIN  = 3'd1,
    B_OCT  = 3'd2,
    B_DEC  = 3'd3,
    B_HEX  = 3'd4
  } base_t;

  typedef struct packed {
    logic [2:0]  base_mode;
    logic [15:0] field_width;
    logic        grouping_enable;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value;
    logic        success;
    logic [15:0] consumed;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [6:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d = c - CH_UC_A + 8'd10;
    end
    return d[6:0];
  endfunction

  function automatic logic [4:0] radix_of(input base_t b);
    logic [4:0] r;
    unique case (b)
      B_BIN:   r = 5'd2;
      B_OCT:   r = 5'd8;
      B_HEX:   r = 5'd16;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

  // acc * radix + digit, all shifts and adds (one extra add for decimal)
  function automatic logic [63:0] mac_radix(input logic [63:0] acc, input base_t b,
                                            input logic [6:0] v);
    logic [63:0] p;
    unique case (b)
      B_BIN:   p = acc << 1;
      B_OCT:   p = acc << 3;
      B_HEX:   p = acc << 4;
      default: p = (acc << 3) + (acc << 1);
    endcase
    return p + 64'(v);
  endfunction

endpackage

[rtl/integer_field_scanner.sv]
// Top level of the integer field scanner: configuration registers and stage wiring.
// Scans one integer field from a text stream, one character per transfer. Leading
// whitespace is skipped, then an optional sign, an optional 0x/0b/0 prefix in automatic
// base (0x also in hex, 0b also in binary), digits (and comma thousands groups in decimal
// when enabled). The character that ends a field produces exactly one result and is
// dropped, unless it used up the field width and so counts into the field; all other
// characters produce none. One character is accepted every cycle while no result waits
// under out_stall, a rate set by the state update's one multiply-add by the radix. The
// result register loads when the engine takes the ending character from the input
// register and drives out_valid; while a result waits under out_stall the input stalls
// as well. Configuration is sampled at the first non-whitespace character of each field.
module integer_field_scanner import ifs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_success,
  output logic [15:0] out_consumed
);

  cfg_t       cfg_r;
  logic       ch_vld;
  logic [7:0] ch;
  logic       out_ready;
  logic       step_en;
  logic       res_vld;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_MODE:       cfg_r.base_mode       <= cfg_data[2:0];
        CFG_FIELD_WIDTH:     cfg_r.field_width     <= cfg_data;
        CFG_GROUPING_ENABLE: cfg_r.grouping_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step_en = ch_vld & out_ready;

  ifs_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_char (in_text_char),
    .take         (step_en),
    .vld          (ch_vld),
    .text_char    (ch)
  );

  ifs_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .text_char (ch),
    .cfg       (cfg_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  ifs_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (res_vld),
    .res          (res),
    .ready        (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_success  (out_success),
    .out_consumed (out_consumed)
  );

endmodule

[rtl/ifs_in_stage.sv]
// Input register stage holding one text character.
module ifs_in_stage import ifs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_char,
  input  logic       take,
  output logic       vld,
  output logic [7:0] text_char
);

  logic       vld_r;
  logic [7:0] char_r;
  logic       accept;

  assign in_stall  = vld_r & ~take;
  assign accept    = in_valid & ~in_stall;
  assign vld       = vld_r;
  assign text_char = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept | (vld_r & ~take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_text_char;
    end
  end

endmodule

[rtl/ifs_engine.sv]
// Per-character field state update and result formation.
module ifs_engine import ifs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] text_char,
  input  cfg_t       cfg,
  output logic       res_vld,
  output result_t    res
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_GROUP  = 3'd4,
    PH_AFTER  = 3'd5
  } phase_t;

  phase_t                ph_r,   ph_nxt;
  logic [63:0]           acc_r,  acc_nxt;
  logic [63:0]           grp_r,  grp_nxt;
  logic [1:0]            la_r,   la_nxt;
  logic [2:0]            dc_r,   dc_nxt;
  logic [15:0]           wl_r,   wl_nxt;
  logic                  wlm_r,  wlm_nxt;
  base_t                 ab_r,   ab_nxt;
  logic                  gl_r,   gl_nxt;
  logic                  neg_r,  neg_nxt;
  logic [COUNT_BITS-1:0] cc_r,   cc_nxt;
  logic                  fin;
  logic [CW-1:0]         cc_ext;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c,
                                                 input logic [2:0] n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, c} + {{(COUNT_BITS-2){1'b0}}, n};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [15:0] take_w(input logic [15:0] w, input logic lim,
                                         input logic [2:0] n);
    logic [15:0] nw;
    nw = {13'd0, n};
    if (!lim) begin
      return w;
    end
    return (w < nw) ? 16'd0 : w - nw;
  endfunction

  always_comb begin
    logic       go_first;
    logic       go_digit;
    logic [6:0] dv;
    logic [7:0] lc;
    logic [63:0] v;
    go_first = 1'b0;
    go_digit = 1'b0;
    fin      = 1'b0;
    dv       = digit_val(text_char);
    lc       = text_char | CH_SPACE;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    grp_nxt  = grp_r;
    la_nxt   = la_r;
    dc_nxt   = dc_r;
    wl_nxt   = wl_r;
    wlm_nxt  = wlm_r;
    ab_nxt   = ab_r;
    gl_nxt   = gl_r;
    neg_nxt  = neg_r;
    cc_nxt   = cc_r;

    unique case (ph_r)
      PH_SIGN: begin
        go_first = 1'b1;
      end
      PH_ZERO: begin
        if ((lc == CH_LC_X && (ab_r == B_AUTO || ab_r == B_HEX)) ||
            (lc == CH_LC_B && (ab_r == B_AUTO || ab_r == B_BIN))) begin
          ab_nxt = (lc == CH_LC_X) ? B_HEX : B_BIN;
          cc_nxt = bump(cc_nxt, 3'd1);
          wl_nxt = take_w(wl_nxt, wlm_nxt, 3'd1);
          dc_nxt = 3'd0;
          ph_nxt = PH_DIGITS;
          if (wlm_nxt && wl_nxt < 16'd1) fin = 1'b1;
        end else begin
          if (ab_nxt == B_AUTO) ab_nxt = B_OCT;
          dc_nxt   = 3'd1;
          go_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        go_digit = 1'b1;
      end
      PH_GROUP: begin
        if (!is_dec_digit(text_char)) begin
          fin = 1'b1;
        end else begin
          grp_nxt = mac_radix(grp_r, B_DEC, dv);
          if (la_r < 2'd2) begin
            la_nxt = la_r + 2'd1;
          end else begin
            acc_nxt = grp_nxt;
            cc_nxt  = bump(cc_nxt, 3'd4);
            wl_nxt  = take_w(wl_nxt, wlm_nxt, 3'd4);
            dc_nxt  = 3'd4;
            la_nxt  = 2'd0;
            ph_nxt  = PH_AFTER;
            if (wlm_nxt && wl_nxt < 16'd4) fin = 1'b1;
          end
        end
      end
      PH_AFTER: begin
        if (text_char == CH_COMMA && (!wlm_r || wl_r >= 16'd4)) begin
          ph_nxt  = PH_GROUP;
          la_nxt  = 2'd0;
          grp_nxt = acc_r;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
        if (is_space(text_char)) begin
          cc_nxt = bump(cc_nxt, 3'd1);
        end else begin
          wlm_nxt = (cfg.field_width != 16'd0);
          wl_nxt  = cfg.field_width;
          ab_nxt  = (cfg.base_mode <= 3'd4) ? base_t'(cfg.base_mode) : B_AUTO;
          gl_nxt  = cfg.grouping_enable;
          if (text_char == CH_MINUS || text_char == CH_PLUS) begin
            neg_nxt = (text_char == CH_MINUS);
            cc_nxt  = bump(cc_nxt, 3'd1);
            wl_nxt  = take_w(wl_nxt, wlm_nxt, 3'd1);
            ph_nxt  = PH_SIGN;
            if (wlm_nxt && wl_nxt < 16'd1) fin = 1'b1;
          end else begin
            go_first = 1'b1;
          end
        end
      end
    endcase

    if (go_first) begin
      if (text_char == CH_ZERO && (!wlm_nxt || wl_nxt >= 16'd2)) begin
        cc_nxt = bump(cc_nxt, 3'd1);
        wl_nxt = take_w(wl_nxt, wlm_nxt, 3'd1);
        ph_nxt = PH_ZERO;
      end else begin
        if (ab_nxt == B_AUTO) ab_nxt = (text_char == CH_ZERO) ? B_OCT : B_DEC;
        go_digit = 1'b1;
      end
    end

    if (go_digit) begin
      if (dv < {2'b00, radix_of(ab_nxt)}) begin
        acc_nxt = mac_radix(acc_nxt, ab_nxt, dv);
        cc_nxt  = bump(cc_nxt, 3'd1);
        wl_nxt  = take_w(wl_nxt, wlm_nxt, 3'd1);
        if (dc_nxt < 3'd4) dc_nxt = dc_nxt + 3'd1;
        ph_nxt  = PH_DIGITS;
        if (wlm_nxt && wl_nxt < 16'd1) fin = 1'b1;
      end else if (gl_nxt && ab_nxt == B_DEC && text_char == CH_COMMA &&
                   dc_nxt >= 3'd1 && dc_nxt <= 3'd3 &&
                   (!wlm_nxt || wl_nxt >= 16'd4)) begin
        ph_nxt  = PH_GROUP;
        la_nxt  = 2'd0;
        grp_nxt = acc_nxt;
      end else begin
        fin = 1'b1;
      end
    end

    v           = neg_nxt ? (64'd0 - acc_nxt) : acc_nxt;
    res.success = (dc_nxt != 3'd0);
    res.value   = res.success ? v : 64'd0;
    cc_ext      = CW'(cc_nxt);
    res.consumed = (cc_ext > CW'(16'hFFFF)) ? 16'hFFFF : cc_ext[15:0];

    if (fin) begin
      ph_nxt  = PH_IDLE;
      acc_nxt = 64'd0;
      grp_nxt = 64'd0;
      la_nxt  = 2'd0;
      dc_nxt  = 3'd0;
      wl_nxt  = 16'd0;
      wlm_nxt = 1'b0;
      ab_nxt  = B_AUTO;
      gl_nxt  = 1'b0;
      neg_nxt = 1'b0;
      cc_nxt  = '0;
    end
  end

  assign res_vld = step_en & fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      acc_r <= 64'd0;
      grp_r <= 64'd0;
      la_r  <= 2'd0;
      dc_r  <= 3'd0;
      wl_r  <= 16'd0;
      wlm_r <= 1'b0;
      ab_r  <= B_AUTO;
      gl_r  <= 1'b0;
      neg_r <= 1'b0;
      cc_r  <= '0;
    end else if (step_en) begin
      ph_r  <= ph_nxt;
      acc_r <= acc_nxt;
      grp_r <= grp_nxt;
      la_r  <= la_nxt;
      dc_r  <= dc_nxt;
      wl_r  <= wl_nxt;
      wlm_r <= wlm_nxt;
      ab_r  <= ab_nxt;
      gl_r  <= gl_nxt;
      neg_r <= neg_nxt;
      cc_r  <= cc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (ph_r == PH_IDLE && cc_r == '0 && dc_r == 3'd0))
    else $error("field state not cleared after result");

  a_la_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_GROUP) |-> (la_r == 2'd0))
    else $error("lookahead count live outside group");

  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= 3'd4)
    else $error("digit count above saturation");

  a_unlimited_width: assert property (@(posedge clk) disable iff (!rst_n)
    !wlm_r |-> (wl_r == 16'd0))
    else $error("width left nonzero without width limit");
`endif

endmodule

[rtl/ifs_out_stage.sv]
// Result register stage driving the output channel.
module ifs_out_stage import ifs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_success,
  output logic [15:0] out_consumed
);

  logic    vld_r;
  result_t res_r;

  assign ready        = ~vld_r | ~out_stall;
  assign out_valid    = vld_r;
  assign out_value    = res_r.value;
  assign out_success  = res_r.success;
  assign out_consumed = res_r.consumed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
